### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

### rtl/core/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Constants, types and update tables for the telemetry packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int PAYLOAD_KEEP = 68;
    localparam int ADDR_W       = $clog2(PAYLOAD_KEEP);

    localparam logic [7:0] HDR_BYTE  = 8'hEE;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [7:0] KIND_ANGLE = 8'h00;
    localparam logic [7:0] KIND_GPS   = 8'h01;
    localparam logic [7:0] KIND_BATT  = 8'h02;
    localparam logic [7:0] KIND_ID    = 8'h03;
    localparam logic [7:0] KIND_PID0  = 8'h04;
    localparam logic [7:0] KIND_PID3  = 8'h07;
    localparam logic [7:0] KIND_ALL   = 8'hFF;

    localparam logic [7:0] MIN_ANGLE = 8'd6;
    localparam logic [7:0] MIN_WORDS = 8'd12;
    localparam logic [7:0] MIN_BYTE  = 8'd1;
    localparam logic [7:0] MIN_ALL   = 8'd68;

    localparam logic [4:0] WORDS_ALL = 5'd20;

    // One update word: where it sits in the payload and how it goes out.
    typedef struct packed {
        logic [4:0] slot;
        logic [6:0] offs;
        logic [1:0] nbytes_m1;
        logic       is_float;
        logic       last;
    } t_word;

    typedef struct packed {
        logic ld_kind;
        logic ld_len;
        logic take_payload;
        logic word_start;
        logic rd_issue;
        logic shift;
        logic word_next;
    } t_dp_cmd;

    typedef struct packed {
        logic is_hdr;
        logic is_tail;
        logic is_zero;
        logic pay_done;
        logic sum_match;
        logic emit_ok;
        logic byte_last;
        logic word_last;
    } t_dp_stat;

    function automatic t_word word_desc(input logic [7:0] kind, input logic [4:0] idx);
        int    k;
        t_word w;
        k = int'(idx);
        w = '0;
        case (kind) inside
            KIND_ANGLE: begin
                w.slot      = 5'(1 + k);
                w.offs      = 7'(2 * k);
                w.nbytes_m1 = 2'd1;
                w.last      = (k == 2);
            end
            KIND_GPS: begin
                w.slot      = 5'(4 + k);
                w.offs      = 7'(4 * k);
                w.nbytes_m1 = 2'd3;
                w.last      = (k == 2);
            end
            KIND_BATT: begin
                w.slot = 5'd7;
                w.last = 1'b1;
            end
            KIND_ID: begin
                w.slot = 5'd0;
                w.last = 1'b1;
            end
            [KIND_PID0:KIND_PID3]: begin
                w.slot      = 5'(8 + 3 * (int'(kind) - 4) + k);
                w.offs      = 7'(4 * k);
                w.nbytes_m1 = 2'd3;
                w.is_float  = 1'b1;
                w.last      = (k == 2);
            end
            KIND_ALL: begin
                w.slot = 5'(k);
                w.last = (k == int'(WORDS_ALL) - 1);
                if (k == 0) begin
                    w.offs = 7'd0;
                end else if (k <= 3) begin
                    w.offs      = 7'(2 * k - 1);
                    w.nbytes_m1 = 2'd1;
                end else if (k <= 6) begin
                    w.offs      = 7'(4 * k - 9);
                    w.nbytes_m1 = 2'd3;
                    w.is_float  = 1'b1;
                end else if (k == 7) begin
                    w.offs = 7'd19;
                end else begin
                    w.offs      = 7'(4 * k - 12);
                    w.nbytes_m1 = 2'd3;
                    w.is_float  = 1'b1;
                end
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    // Known status with enough payload for its updates.
    function automatic logic emit_allowed(input logic [7:0] kind, input logic [7:0] len);
        logic ok;
        case (kind) inside
            KIND_ANGLE:            ok = (len >= MIN_ANGLE);
            KIND_GPS:              ok = (len >= MIN_WORDS);
            KIND_BATT, KIND_ID:    ok = (len >= MIN_BYTE);
            [KIND_PID0:KIND_PID3]: ok = (len >= MIN_WORDS);
            KIND_ALL:              ok = (len >= MIN_ALL);
            default:               ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

### rtl/core/tpd_ram.sv
// ----------------------------------------------------------------------------
// tpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 68
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tpd_datapath.sv
// ----------------------------------------------------------------------------
// tpd_datapath
// Packet fields, running sum, payload store and update word assembly.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpd_datapath
    import tpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_byte,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic [4:0]  o_slot,
    output logic [31:0] o_value,
    output logic        o_is_float,
    output logic        o_last
);

    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_sum, n_sum;
    logic [4:0]  r_word, n_word;
    logic [1:0]  r_bidx, n_bidx;
    logic [31:0] r_acc, n_acc;

    t_word       w_cur;
    logic [7:0]  cnt_inc;
    logic [7:0]  addr_sum;
    logic [7:0]  rdata;
    logic        store_we;

    assign w_cur    = word_desc(r_kind, r_word);
    assign cnt_inc  = r_cnt + 8'd1;
    assign addr_sum = 8'(w_cur.offs) + 8'(r_bidx);
    assign store_we = i_cmd.take_payload && (r_cnt < 8'(PAYLOAD_KEEP));

    tpd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_KEEP)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (ADDR_W'(r_cnt)),
        .i_wdata (i_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (ADDR_W'(addr_sum)),
        .o_rdata (rdata)
    );

    always_comb begin
        n_kind = r_kind;
        n_len  = r_len;
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_word = r_word;
        n_bidx = r_bidx;
        n_acc  = r_acc;
        if (i_cmd.ld_kind) begin
            n_kind = i_byte;
            n_sum  = i_byte;
        end
        if (i_cmd.ld_len) begin
            n_len = i_byte;
            n_sum = r_sum + i_byte;
            n_cnt = 8'd0;
        end
        if (i_cmd.take_payload) begin
            n_sum = r_sum + i_byte;
            n_cnt = cnt_inc;
        end
        if (i_cmd.word_start) begin
            n_word = 5'd0;
            n_bidx = 2'd0;
            n_acc  = '0;
        end
        if (i_cmd.shift) begin
            // big-endian: earlier bytes move up
            n_acc  = {r_acc[23:0], rdata};
            n_bidx = r_bidx + 2'd1;
        end
        if (i_cmd.word_next) begin
            n_word = r_word + 5'd1;
            n_bidx = 2'd0;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= '0;
            r_len  <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_word <= '0;
            r_bidx <= '0;
        end else begin
            r_kind <= n_kind;
            r_len  <= n_len;
            r_cnt  <= n_cnt;
            r_sum  <= n_sum;
            r_word <= n_word;
            r_bidx <= n_bidx;
        end
        r_acc <= n_acc;
    end

    always_comb begin
        o_stat.is_hdr    = (i_byte == HDR_BYTE);
        o_stat.is_tail   = (i_byte == TAIL_BYTE);
        o_stat.is_zero   = (i_byte == ZERO_BYTE);
        o_stat.pay_done  = (cnt_inc == r_len);
        o_stat.sum_match = (i_byte == r_sum);
        o_stat.emit_ok   = emit_allowed(r_kind, r_len);
        o_stat.byte_last = (r_bidx == w_cur.nbytes_m1);
        o_stat.word_last = w_cur.last;
    end

    assign o_slot     = w_cur.slot;
    assign o_value    = r_acc;
    assign o_is_float = w_cur.is_float;
    assign o_last     = w_cur.last;

    `ASSERT_CLK(a_word_in_range, i_clk, i_rst_n, (r_word < WORDS_ALL))

endmodule

### rtl/core/tpd_ctrl.sv
// ----------------------------------------------------------------------------
// tpd_ctrl
// Packet framing state machine and update run sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpd_ctrl
    import tpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_HUNT0   = 4'd0;
    localparam logic [3:0] S_HUNT1   = 4'd1;
    localparam logic [3:0] S_ID      = 4'd2;
    localparam logic [3:0] S_STATUS  = 4'd3;
    localparam logic [3:0] S_LENGTH  = 4'd4;
    localparam logic [3:0] S_PAYLOAD = 4'd5;
    localparam logic [3:0] S_CHECK   = 4'd6;
    localparam logic [3:0] S_TAIL    = 4'd7;
    localparam logic [3:0] S_READ    = 4'd8;
    localparam logic [3:0] S_SHIFT   = 4'd9;
    localparam logic [3:0] S_SHOW    = 4'd10;

    logic [3:0] r_state, n_state;
    logic       s_xfer;
    logic       m_xfer;

    assign o_s_ready = (r_state <= S_TAIL);
    assign o_m_valid = (r_state == S_SHOW);
    assign s_xfer    = i_s_valid && o_s_ready;
    assign m_xfer    = o_m_valid && i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT0: begin
                if (s_xfer && i_stat.is_hdr) n_state = S_HUNT1;
            end
            S_HUNT1: begin
                if (s_xfer) n_state = i_stat.is_hdr ? S_ID : S_HUNT0;
            end
            S_ID: begin
                if (s_xfer) n_state = S_STATUS;
            end
            S_STATUS: begin
                if (s_xfer) begin
                    o_cmd.ld_kind = 1'b1;
                    n_state       = S_LENGTH;
                end
            end
            S_LENGTH: begin
                if (s_xfer) begin
                    o_cmd.ld_len = 1'b1;
                    n_state      = i_stat.is_zero ? S_CHECK : S_PAYLOAD;
                end
            end
            S_PAYLOAD: begin
                if (s_xfer) begin
                    o_cmd.take_payload = 1'b1;
                    if (i_stat.pay_done) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (s_xfer) n_state = i_stat.sum_match ? S_TAIL : S_HUNT0;
            end
            S_TAIL: begin
                if (s_xfer) begin
                    if (i_stat.is_tail && i_stat.emit_ok) begin
                        o_cmd.word_start = 1'b1;
                        n_state          = S_READ;
                    end else begin
                        n_state = S_HUNT0;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_stat.byte_last ? S_SHOW : S_READ;
            end
            S_SHOW: begin
                // hold the word until the transfer completes
                if (m_xfer) begin
                    if (i_stat.word_last) begin
                        n_state = S_HUNT0;
                    end else begin
                        o_cmd.word_next = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            default: n_state = S_HUNT0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT0;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEVER(a_in_out_exclusive, i_clk, i_rst_n, o_s_ready && o_m_valid)
    `ASSERT_CLK(a_read_then_shift, i_clk, i_rst_n, (r_state == S_READ) |=> (r_state == S_SHIFT))
    `ASSERT_CLK(a_next_word_reads, i_clk, i_rst_n,
        (m_xfer && !i_stat.word_last) |=> (r_state == S_READ))

endmodule

### rtl/core/telemetry_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// telemetry_packet_deframer_core
// Takes one byte per cycle while framing a packet.
// A valid tail starts an update run: each word reads its payload bytes one
// at a time through the single read port of the payload store, shifting each
// in, then shows the word until it is taken; input is held off for the run.
// Synchronous active-low reset returns to the header hunt; no clearing pass.
// ----------------------------------------------------------------------------
module telemetry_packet_deframer_core
    import tpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] slot, [36:5] value, [39:37] zero
    output logic [0:0]  m_axis_tuser,   // [0] value_is_float
    output logic        m_axis_tlast
);

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [4:0]  slot;
    logic [31:0] value;
    logic        is_float;
    logic        last;

    tpd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    tpd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (s_axis_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_slot     (slot),
        .o_value    (value),
        .o_is_float (is_float),
        .o_last     (last)
    );

    assign m_axis_tdata = {3'b000, value, slot};
    assign m_axis_tuser = is_float;
    assign m_axis_tlast = last;

endmodule

### tb/sv/telemetry_update_checker.sv
// ----------------------------------------------------------------------------
// telemetry_update_checker
// Watches both stream ports of the deframer, tracks packet framing on every
// accepted byte, queues the slot/value updates a valid packet must produce and
// compares each update transfer field by field against the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telemetry_update_checker
    import tpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [4:0] slot, [36:5] value, [39:37] zero
    input  logic [0:0]  m_axis_tuser,   // [0] value_is_float
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [2:0] {
        SYNC0, SYNC1, GET_ID, GET_STATUS, GET_LEN, GET_PAYLOAD, GET_CSUM, GET_TAIL
    } t_frame_state;

    typedef struct packed {
        logic [4:0]  slot;
        logic [31:0] value;
        logic        is_float;
        logic        last;
    } t_update;

    t_frame_state fstate;
    logic [7:0]   cur_kind;
    logic [7:0]   cur_len;
    logic [7:0]   cur_count;
    logic [7:0]   cur_sum;
    logic [7:0]   pay_mem [PAYLOAD_KEEP];
    t_update      updates_due [$];
    t_update      run_buf [20];
    int           run_len;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Big-endian word of nbytes payload bytes starting at offs.
    function automatic logic [31:0] payload_word(input int offs, input int nbytes);
        logic [31:0] w;
        int          i;
        w = '0;
        for (i = 0; i < nbytes; i++) begin
            w = {w[23:0], pay_mem[offs + i]};
        end
        return w;
    endfunction

    task automatic add_update(input int slot, input logic [31:0] value, input logic is_float);
        run_buf[run_len] = '{slot: 5'(slot), value: value, is_float: is_float, last: 1'b0};
        run_len++;
    endtask

    task automatic queue_updates();
        int      k;
        t_update u;
        run_len = 0;
        if (cur_kind == KIND_ANGLE && cur_len >= MIN_ANGLE) begin
            for (k = 0; k < 3; k++) add_update(1 + k, payload_word(2 * k, 2), 1'b0);
        end else if (cur_kind == KIND_GPS && cur_len >= MIN_WORDS) begin
            for (k = 0; k < 3; k++) add_update(4 + k, payload_word(4 * k, 4), 1'b0);
        end else if (cur_kind == KIND_BATT && cur_len >= MIN_BYTE) begin
            add_update(7, payload_word(0, 1), 1'b0);
        end else if (cur_kind == KIND_ID && cur_len >= MIN_BYTE) begin
            add_update(0, payload_word(0, 1), 1'b0);
        end else if (cur_kind >= KIND_PID0 && cur_kind <= KIND_PID3
                     && cur_len >= MIN_WORDS) begin
            for (k = 0; k < 3; k++) begin
                add_update(8 + 3 * (int'(cur_kind) - int'(KIND_PID0)) + k,
                           payload_word(4 * k, 4), 1'b1);
            end
        end else if (cur_kind == KIND_ALL && cur_len >= MIN_ALL) begin
            add_update(0, payload_word(0, 1), 1'b0);
            for (k = 0; k < 3; k++) add_update(1 + k, payload_word(1 + 2 * k, 2), 1'b0);
            for (k = 0; k < 3; k++) add_update(4 + k, payload_word(7 + 4 * k, 4), 1'b1);
            add_update(7, payload_word(19, 1), 1'b0);
            for (k = 0; k < 12; k++) add_update(8 + k, payload_word(20 + 4 * k, 4), 1'b1);
        end
        for (k = 0; k < run_len; k++) begin
            u      = run_buf[k];
            u.last = (k == run_len - 1);
            updates_due.push_back(u);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        case (fstate)
            SYNC0: begin
                if (b == HDR_BYTE) fstate = SYNC1;
            end
            SYNC1: begin
                if (b == HDR_BYTE) fstate = GET_ID;
                else fstate = SYNC0;
            end
            GET_ID: begin
                fstate = GET_STATUS;
            end
            GET_STATUS: begin
                cur_kind = b;
                cur_sum  = b;
                fstate   = GET_LEN;
            end
            GET_LEN: begin
                cur_len   = b;
                cur_sum   = cur_sum + b;
                cur_count = '0;
                if (b == ZERO_BYTE) fstate = GET_CSUM;
                else fstate = GET_PAYLOAD;
            end
            GET_PAYLOAD: begin
                // keep the head of the payload, sum all of it
                if (cur_count < PAYLOAD_KEEP) pay_mem[cur_count] = b;
                cur_sum   = cur_sum + b;
                cur_count = cur_count + 8'd1;
                if (cur_count == cur_len) fstate = GET_CSUM;
            end
            GET_CSUM: begin
                if (b == cur_sum) fstate = GET_TAIL;
                else fstate = SYNC0;
            end
            default: begin
                if (b == TAIL_BYTE) queue_updates();
                fstate = SYNC0;
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_update want;
        if (!i_rst_n) begin
            fstate    = SYNC0;
            cur_kind  = '0;
            cur_len   = '0;
            cur_count = '0;
            cur_sum   = '0;
            updates_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (updates_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: update transfer with none due, expected nothing, actual %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = updates_due.pop_front();
                    check_field("slot", 32'(want.slot), 32'(m_axis_tdata[4:0]));
                    check_field("value", want.value, m_axis_tdata[36:5]);
                    check_field("zero fill", 32'd0, 32'(m_axis_tdata[39:37]));
                    check_field("value_is_float", 32'(want.is_float), 32'(m_axis_tuser[0]));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
        end
        o_pending = updates_due.size();
    end

endmodule

### tb/sv/tb_telemetry_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_telemetry_packet_deframer_core
// Feeds framed telemetry packets, broken frames and line noise into the
// deframer with random sender gaps and receiver stalls; the update checker
// predicts and compares the update stream and reports failures here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_telemetry_packet_deframer_core;
    import tpd_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [4:0] slot, [36:5] value, [39:37] zero
    logic [0:0]  m_axis_tuser;         // [0] value_is_float
    logic        m_axis_tlast;

    int         fail_count;
    int         updates_pending;
    int         rx_hold_asks  = 0;
    int         rx_holds_done = 0;
    int         rx_stall_left = 0;
    int         rx_free_left  = 0;
    int         tx_free_left  = 0;
    logic [7:0] frame_pay [256];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    telemetry_packet_deframer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    telemetry_update_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (updates_pending)
    );

    // Receiver: short random stalls, free-running stretches, long hold on request.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (rx_holds_done < rx_hold_asks) begin
            rx_holds_done <= rx_holds_done + 1;
            rx_stall_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_free_left > 0) begin
            rx_free_left  <= rx_free_left - 1;
            m_axis_tready <= 1'b1;
        end else if (r < 3) begin
            rx_free_left  <= $urandom_range(20, 80);
            m_axis_tready <= 1'b1;
        end else if (r < 5) begin
            rx_stall_left <= $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end else if (r < 30) begin
            rx_stall_left <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one byte, hold it until the transfer, then maybe idle a while.
    task automatic push_byte(input logic [7:0] b);
        int r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        r   = $urandom_range(0, 99);
        gap = 0;
        if (tx_free_left > 0) begin
            tx_free_left--;
        end else if (r < 50) begin
            gap = 0;
        end else if (r < 80) begin
            gap = $urandom_range(1, 3);
        end else if (r < 93) begin
            gap = $urandom_range(4, 10);
        end else if (r < 97) begin
            gap = $urandom_range(20, 60);
        end else begin
            tx_free_left = $urandom_range(30, 100);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic fill_payload(input int len);
        int i;
        for (i = 0; i < len; i++) frame_pay[i] = 8'($urandom_range(0, 255));
    endtask

    task automatic send_frame(input logic [7:0] id, input logic [7:0] kind,
                              input logic [7:0] len, input logic bad_sum,
                              input logic [7:0] tail);
        logic [7:0] sum;
        int         i;
        sum = kind + len;
        for (i = 0; i < int'(len); i++) sum = sum + frame_pay[i];
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(HDR_BYTE);
        push_byte(HDR_BYTE);
        push_byte(id);
        push_byte(kind);
        push_byte(len);
        for (i = 0; i < int'(len); i++) push_byte(frame_pay[i]);
        push_byte(sum);
        push_byte(tail);
    endtask

    task automatic valid_frame(input logic [7:0] kind, input logic [7:0] len);
        fill_payload(int'(len));
        send_frame(8'($urandom_range(0, 255)), kind, len, 1'b0, TAIL_BYTE);
    endtask

    // Stop offering and wait until every predicted update has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (updates_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // broken header, then an EE right after the header taken as id
        push_byte(ZERO_BYTE);
        push_byte(HDR_BYTE);
        push_byte(8'h5A);
        frame_pay[0] = 8'hFF;
        send_frame(HDR_BYTE, KIND_ID, MIN_BYTE, 1'b0, TAIL_BYTE);

        valid_frame(KIND_PID0 + 8'($urandom_range(0, 3)), MIN_WORDS);
        valid_frame(KIND_ALL, MIN_ALL);

        // hold the receiver off during the full run while the next packets wait;
        // a bad tail must not count as a header byte, a zero length gives nothing
        rx_hold_asks <= rx_hold_asks + 1;
        fill_payload(1);
        send_frame(8'h22, KIND_ID, MIN_BYTE, 1'b0, HDR_BYTE);
        valid_frame(KIND_BATT, MIN_BYTE);
        valid_frame(KIND_ANGLE, ZERO_BYTE);
        drain();

        // bad checksum
        fill_payload(1);
        send_frame(8'h11, KIND_BATT, MIN_BYTE, 1'b1, TAIL_BYTE);

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && updates_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tpd_pkg.sv
rtl/core/tpd_ram.sv
rtl/core/tpd_datapath.sv
rtl/core/tpd_ctrl.sv
rtl/core/telemetry_packet_deframer_core.sv
tb/sv/telemetry_update_checker.sv
tb/sv/tb_telemetry_packet_deframer_core.sv
